### sv/gray_code_plane_decoder_unit_defines.svh
// Assertion macros shared by the gray code plane decoder RTL.
`ifndef GRAY_CODE_PLANE_DECODER_UNIT_DEFINES_SVH
`define GRAY_CODE_PLANE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define GCPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gcpd: same-cycle check failed");

// Next-cycle implication, clocked on aclk, off during reset.
`define GCPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gcpd: next-cycle check failed");

`endif

### sv/gcpd_pkg.sv
// Types, constants and register indexes of the gray code plane decoder.
package gcpd_pkg;

    localparam int PIX_W         = 18;
    localparam int COORD_W       = 12;
    localparam int PLANE_W       = 4;
    localparam int BITS_W        = 4;
    localparam int CFG_IDX_W     = 1;
    localparam int DEF_PIXELS    = 262144;
    localparam int DEF_CODE_BITS = 12;
    localparam int QUEUE_DEPTH   = 4;
    localparam int OUT_DEPTH     = 4;

    localparam logic [BITS_W-1:0]    RESET_BITS = 4'd10;
    localparam logic [CFG_IDX_W-1:0] CFG_X_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_BITS = 1'd1;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_index;
        logic               axis;
        logic [PLANE_W-1:0] plane;
        logic [7:0]         positive;
        logic [7:0]         negative;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_out;
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
    } out_item_t;

    // Classified plane update handed from front to back.
    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic              axis;
        logic [BITS_W-1:0] pos_bit;
        logic              bitval;
        logic              clear;
        logic              emit;
    } op_t;

endpackage

### sv/gcpd_ram.sv
// Generic simple dual-port RAM with registered read.
module gcpd_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/gcpd_fifo.sv
// Small register FIFO with valid/ready on both sides and a fill count.
`include "gray_code_plane_decoder_unit_defines.svh"

module gcpd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data,
    output logic [CW-1:0]    count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = (cnt_reg < CW'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign count     = cnt_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    `GCPD_ASSERT_NEXT(a_fifo_fill, pop && !push, cnt_reg == $past(cnt_reg) - 1'b1)

endmodule

### sv/gcpd_front.sv
// Front end: holds the bit-count registers, accepts and classifies plane items.
`include "gray_code_plane_decoder_unit_defines.svh"

module gcpd_front #(
    parameter int PIXELS    = gcpd_pkg::DEF_PIXELS,
    parameter int CODE_BITS = gcpd_pkg::DEF_CODE_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [gcpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gcpd_pkg::BITS_W-1:0]        cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  gcpd_pkg::in_item_t                 s_data,
    output logic                               op_valid,
    input  logic                               op_ready,
    output gcpd_pkg::op_t                      op
);

    import gcpd_pkg::*;

    logic [BITS_W-1:0] x_bits_reg, x_bits_next;
    logic [BITS_W-1:0] y_bits_reg, y_bits_next;
    logic [BITS_W:0]   eff_x, eff_y, bits, plane_ext;
    logic              pix_ok, plane_ok, keep;

    always_comb begin
        x_bits_next = x_bits_reg;
        y_bits_next = y_bits_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_X_BITS: x_bits_next = cfg_wdata;
                CFG_Y_BITS: y_bits_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_bits_reg <= RESET_BITS;
            y_bits_reg <= RESET_BITS;
        end else begin
            x_bits_reg <= x_bits_next;
            y_bits_reg <= y_bits_next;
        end
    end

    always_comb begin
        eff_x = ({1'b0, x_bits_reg} > (BITS_W + 1)'(CODE_BITS)) ?
                (BITS_W + 1)'(CODE_BITS) : {1'b0, x_bits_reg};
        eff_y = ({1'b0, y_bits_reg} > (BITS_W + 1)'(CODE_BITS)) ?
                (BITS_W + 1)'(CODE_BITS) : {1'b0, y_bits_reg};
        bits      = s_data.axis ? eff_y : eff_x;
        plane_ext = (BITS_W + 1)'(s_data.plane);
        pix_ok    = (32'(s_data.pixel_index) < 32'(PIXELS));
        plane_ok  = (plane_ext < bits);
        keep      = pix_ok && plane_ok;

        op.pixel   = s_data.pixel_index;
        op.axis    = s_data.axis;
        op.pos_bit = BITS_W'(bits - 1'b1 - plane_ext);
        op.bitval  = (s_data.positive > s_data.negative);
        op.clear   = (s_data.plane == '0);
        op.emit    = s_data.axis && (plane_ext == bits - 1'b1);
    end

    // Out-of-range items are taken and dropped here.
    assign s_ready  = op_ready;
    assign op_valid = s_valid && keep;

    `GCPD_ASSERT_IMPL(a_emit_lsb, op_valid && op.emit, op.axis && (op.pos_bit == '0))

endmodule

### sv/gcpd_back.sv
// Back end: per-pixel read-modify-write of the Gray code stores and coordinate output.
`include "gray_code_plane_decoder_unit_defines.svh"

module gcpd_back #(
    parameter int PIXELS    = gcpd_pkg::DEF_PIXELS,
    parameter int CODE_BITS = gcpd_pkg::DEF_CODE_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  op_valid,
    output logic                  op_ready,
    input  gcpd_pkg::op_t         op,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gcpd_pkg::out_item_t   m_data
);

    import gcpd_pkg::*;

    localparam int AW  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    logic                 s1_valid_reg;
    op_t                  s1_op_reg;
    logic                 lw_valid_reg;
    logic                 lw_axis_reg;
    logic [AW-1:0]        lw_addr_reg;
    logic [CODE_BITS-1:0] lw_code_reg;

    logic [AW-1:0]        rd_addr, s1_addr;
    logic [31:0]          rd_pix_ext, s1_pix_ext;
    logic [CODE_BITS-1:0] x_rd, y_rd, x_old, y_old, base, onehot, new_code;
    logic [CODE_BITS-1:0] x_bin, y_bin, x_code, y_code;
    logic                 pop, wr_x, wr_y, out_push, out_ready;
    logic [OCW-1:0]       out_cnt;
    out_item_t            out_item;

    // One result slot is reserved for the item being updated.
    assign op_ready   = ((OCW + 1)'(out_cnt) + (OCW + 1)'(s1_valid_reg)) <
                        (OCW + 1)'(OUT_DEPTH);
    assign pop        = op_valid && op_ready;
    assign rd_pix_ext = 32'(op.pixel);
    assign rd_addr    = rd_pix_ext[AW-1:0];
    assign s1_pix_ext = 32'(s1_op_reg.pixel);
    assign s1_addr    = s1_pix_ext[AW-1:0];

    gcpd_ram #(.WIDTH(CODE_BITS), .DEPTH(PIXELS), .AW(AW)) u_x_store (
        .aclk    (aclk),
        .wr_en   (wr_x),
        .wr_addr (s1_addr),
        .wr_data (new_code),
        .rd_en   (pop),
        .rd_addr (rd_addr),
        .rd_data (x_rd)
    );

    gcpd_ram #(.WIDTH(CODE_BITS), .DEPTH(PIXELS), .AW(AW)) u_y_store (
        .aclk    (aclk),
        .wr_en   (wr_y),
        .wr_addr (s1_addr),
        .wr_data (new_code),
        .rd_en   (pop),
        .rd_addr (rd_addr),
        .rd_data (y_rd)
    );

    always_comb begin
        // Write of the previous cycle is not yet in the read data.
        x_old = (lw_valid_reg && !lw_axis_reg && (lw_addr_reg == s1_addr)) ? lw_code_reg : x_rd;
        y_old = (lw_valid_reg && lw_axis_reg && (lw_addr_reg == s1_addr)) ? lw_code_reg : y_rd;
        base  = s1_op_reg.clear ? '0 : (s1_op_reg.axis ? y_old : x_old);
        for (int i = 0; i < CODE_BITS; i++) begin
            onehot[i] = (s1_op_reg.pos_bit == BITS_W'(i));
        end
        new_code = (base & ~onehot) | (s1_op_reg.bitval ? onehot : '0);
        wr_x     = s1_valid_reg && !s1_op_reg.axis;
        wr_y     = s1_valid_reg && s1_op_reg.axis;
        out_push = s1_valid_reg && s1_op_reg.emit;
    end

    always_comb begin
        x_code = x_old;
        y_code = new_code;
        for (int i = 0; i < CODE_BITS; i++) begin
            x_bin[i] = ^(x_code >> i);
            y_bin[i] = ^(y_code >> i);
        end
        out_item.pixel_out = s1_op_reg.pixel;
        out_item.x_coord   = COORD_W'(32'(x_bin));
        out_item.y_coord   = COORD_W'(32'(y_bin));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= pop;
            lw_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_op_reg <= op;
        end
        lw_axis_reg <= s1_op_reg.axis;
        lw_addr_reg <= s1_addr;
        lw_code_reg <= new_code;
    end

    gcpd_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_DEPTH), .CW(OCW)) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (out_push),
        .in_ready  (out_ready),
        .in_data   (out_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data),
        .count     (out_cnt)
    );

    `GCPD_ASSERT_IMPL(a_out_room, out_push, out_ready)
    `GCPD_ASSERT_NEXT(a_fwd_pair, pop, s1_valid_reg)

endmodule

### sv/gray_code_plane_decoder_unit.sv
// Top level of the structured-light Gray code plane decoder.
//
// Takes one bit-plane sample pair per cycle, sustained while the output is not
// stalled, with valid/ready on both sides; after the last vertical plane of a
// pixel is transferred, its result passes the queue, s1 stage and output FIFO.
// Throughput is set by the per-pixel read-modify-write of the two Gray code
// stores (PIXELS x CODE_BITS simple dual-port RAMs, registered read), whose
// back-to-back hazard on one pixel is covered by forwarding the previous
// cycle's write. The stores have no reset and no clearing pass: a pixel must
// see its plane 0 on both axes before its coordinates mean anything. x_bits
// and y_bits must be written through cfg_wr_en/cfg_index/cfg_wdata only while
// the block is idle, not enforced by it; values above CODE_BITS act as CODE_BITS.
module gray_code_plane_decoder_unit #(
    parameter int PIXELS    = gcpd_pkg::DEF_PIXELS,
    parameter int CODE_BITS = gcpd_pkg::DEF_CODE_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [gcpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gcpd_pkg::BITS_W-1:0]     cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  gcpd_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output gcpd_pkg::out_item_t             m_data
);

    import gcpd_pkg::*;

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic           f_valid, f_ready;
    op_t            f_op;
    logic           b_valid, b_ready;
    op_t            b_op;
    logic [QCW-1:0] q_cnt;
    logic           q_busy;

    gcpd_front #(.PIXELS(PIXELS), .CODE_BITS(CODE_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .op_valid  (f_valid),
        .op_ready  (f_ready),
        .op        (f_op)
    );

    gcpd_fifo #(.WIDTH($bits(op_t)), .DEPTH(QUEUE_DEPTH), .CW(QCW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_op),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_op),
        .count     (q_cnt)
    );

    assign q_busy = (q_cnt != '0);

    gcpd_back #(.PIXELS(PIXELS), .CODE_BITS(CODE_BITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (b_valid && q_busy),
        .op_ready (b_ready),
        .op       (b_op),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
